// File: hdl/ffha_pkg.sv
// Shared constants, header word layout, controller states and the command/status
// structs of the first-fit heap allocator. No dependencies.
package ffha_pkg;

	// Header store geometry
	localparam int HEAP_GRANULES = 4096;
	localparam int GRAN_W        = $clog2(HEAP_GRANULES);   // header store address
	localparam int FRONT_W       = GRAN_W + 1;              // frontier, 0..HEAP_GRANULES
	localparam int SIZE_W        = 16;                      // stored payload granules

	// Field widths
	localparam int ADDR_W      = 32;
	localparam int HSIZE_W     = 16;
	localparam int REQ_GRAN_W  = 30;                        // ceil(2^32-1 / 8)
	localparam int NEED_W      = REQ_GRAN_W + 1;
	localparam int AVAIL_W     = HSIZE_W + 1;
	localparam int CFG_IDX_W   = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 2'd1;

	// Opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_BUMP,
		ST_FREE_CHK,
		ST_FREE_WR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load_in;    // capture input transfer
		logic prep;       // derive granules, window bounds; rewind walk pointer
		logic walk_rd;    // read header at walk pointer
		logic walk_take;  // claim header just read
		logic walk_step;  // advance walk pointer past block just read
		logic bump;       // try to carve a block at the frontier
		logic free_chk;   // validate free pointer, read its header
		logic free_wr;    // write header back with free mark set
		logic out_load;   // move result into output register
	} cmd_t;

	typedef struct packed {
		logic is_free;    // captured opcode is a free
		logic walk_more;  // walk pointer below frontier
		logic hit;        // header read is free and large enough
		logic free_ok;    // free pointer names a header below frontier
	} status_t;

endpackage

// File: hdl/ffha_dp.sv
// Datapath: configuration registers, request capture, window bounds, walk pointer,
// frontier, header store and result registers. Uses ffha_pkg.
module ffha_dp
	import ffha_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_opcode,
	input  logic [ADDR_W-1:0]    in_request_size,
	input  logic [ADDR_W-1:0]    in_block_pointer,
	output logic [ADDR_W-1:0]    payload_address,
	output logic                 out_of_memory
);

	logic [ADDR_W-1:0]     base_q;
	logic [HSIZE_W-1:0]    size_q;
	logic [FRONT_W-1:0]    frontier_q;

	logic                  op_q;
	logic [ADDR_W-1:0]     req_q;
	logic [ADDR_W-1:0]     ptr_q;

	logic [REQ_GRAN_W-1:0] gran_q;
	logic [ADDR_W:0]       lo_q;       // aligned start + 8
	logic [AVAIL_W-1:0]    avail_q;
	logic [FRONT_W-1:0]    p_q;
	logic [GRAN_W-1:0]     idx_q;

	logic [ADDR_W-1:0]     res_addr_q;
	logic                  res_oom_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic                  out_oom_q;

	hdr_t                  mem [HEAP_GRANULES];
	hdr_t                  rd_data_q;
	logic                  rd_en;
	logic [GRAN_W-1:0]     rd_addr;
	logic                  wr_en;
	logic [GRAN_W-1:0]     wr_addr;
	hdr_t                  wr_data;

	// window bounds
	logic [ADDR_W:0]       start_c;
	logic [ADDR_W:0]       end_c;
	logic [ADDR_W:0]       end_cap;
	logic [AVAIL_W-1:0]    avail_c;
	logic [ADDR_W:0]       lo_c;
	logic [REQ_GRAN_W-1:0] gran_c;

	// bump
	logic [NEED_W-1:0]     need;
	logic [NEED_W+2:0]     need_bytes;
	logic                  fits;

	// free
	logic [ADDR_W+1:0]     dsub;
	logic [ADDR_W-3:0]     didx;

	logic [ADDR_W:0]       hit_addr;

	always_comb begin
		start_c = ({1'b0, base_q} + (ADDR_W+1)'(7)) & ~(ADDR_W+1)'(7);
		lo_c    = ({1'b0, base_q} + (ADDR_W+1)'(15)) & ~(ADDR_W+1)'(7);
		end_c   = {1'b0, base_q} + (ADDR_W+1)'(size_q);
		end_cap = end_c[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : end_c;
		avail_c = (end_cap > start_c) ? AVAIL_W'(end_cap - start_c) : '0;
		if (req_q == '0) begin
			gran_c = REQ_GRAN_W'(1);
		end else begin
			gran_c = REQ_GRAN_W'(({1'b0, req_q} + (ADDR_W+1)'(7)) >> 3);
		end
	end

	assign need       = NEED_W'(frontier_q) + NEED_W'(1) + NEED_W'(gran_q);
	assign need_bytes = {need, 3'b000};
	assign fits       = (need <= NEED_W'(HEAP_GRANULES)) &&
	                    (need_bytes <= (NEED_W+3)'(avail_q));

	assign dsub = {2'b00, ptr_q} - {1'b0, lo_q};
	assign didx = dsub[ADDR_W-1:3];

	assign hit_addr = lo_q + (ADDR_W+1)'({p_q, 3'b000});

	assign sts.is_free   = (op_q == OP_FREE);
	assign sts.walk_more = (p_q < frontier_q);
	assign sts.hit       = rd_data_q.free && (REQ_GRAN_W'(rd_data_q.size) >= gran_q);
	assign sts.free_ok   = (ptr_q != '0) && !dsub[ADDR_W+1] && !dsub[ADDR_W] &&
	                       (dsub[2:0] == 3'b000) && (didx < (ADDR_W-3)'(frontier_q));

	// header store ports
	always_comb begin
		rd_en   = cmd.walk_rd || cmd.free_chk;
		rd_addr = cmd.free_chk ? didx[GRAN_W-1:0] : p_q[GRAN_W-1:0];
		wr_en   = 1'b0;
		wr_addr = p_q[GRAN_W-1:0];
		wr_data = '{free: 1'b0, size: rd_data_q.size};
		if (cmd.walk_take) begin
			wr_en = 1'b1;
		end else if (cmd.bump) begin
			wr_en   = fits;
			wr_addr = frontier_q[GRAN_W-1:0];
			wr_data = '{free: 1'b0, size: SIZE_W'(gran_q)};
		end else if (cmd.free_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_data = '{free: 1'b1, size: rd_data_q.size};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// configuration and frontier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			size_q     <= '0;
			frontier_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEAP_BASE: begin
					base_q     <= cfg_data;
					frontier_q <= '0;
				end
				REG_HEAP_SIZE: begin
					size_q     <= cfg_data[HSIZE_W-1:0];
					frontier_q <= '0;
				end
				default: ;
			endcase
		end else if (cmd.bump && fits) begin
			frontier_q <= FRONT_W'(need);
		end
	end

	// request, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= in_opcode;
			req_q <= in_request_size;
			ptr_q <= in_block_pointer;
		end
		if (cmd.prep) begin
			gran_q  <= gran_c;
			lo_q    <= lo_c;
			avail_q <= avail_c;
			p_q     <= '0;
		end else if (cmd.walk_step) begin
			p_q <= p_q + FRONT_W'(1) + FRONT_W'(rd_data_q.size);
		end
		if (cmd.walk_take) begin
			res_addr_q <= hit_addr[ADDR_W-1:0];
			res_oom_q  <= 1'b0;
		end else if (cmd.bump) begin
			res_addr_q <= fits ? ADDR_W'(lo_q + (ADDR_W+1)'({frontier_q, 3'b000})) : '0;
			res_oom_q  <= !fits;
		end else if (cmd.free_chk) begin
			res_addr_q <= '0;
			res_oom_q  <= 1'b0;
			idx_q      <= didx[GRAN_W-1:0];
		end
		if (cmd.out_load) begin
			out_addr_q <= res_addr_q;
			out_oom_q  <= res_oom_q;
		end
	end

	assign payload_address = out_addr_q;
	assign out_of_memory   = out_oom_q;

endmodule

// File: hdl/ffha_ctrl.sv
// Controller: sequences capture, header walk, bump, free and result hand-off.
// Uses ffha_pkg; drives the datapath through cmd_t and reads status_t.
module ffha_ctrl
	import ffha_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid) state_nxt = ST_PREP;
			ST_PREP:     state_nxt = sts.is_free ? ST_FREE_CHK : ST_WALK_RD;
			ST_WALK_RD:  state_nxt = sts.walk_more ? ST_WALK_CHK : ST_BUMP;
			ST_WALK_CHK: state_nxt = sts.hit ? ST_RESP : ST_WALK_RD;
			ST_BUMP:     state_nxt = ST_RESP;
			ST_FREE_CHK: state_nxt = sts.free_ok ? ST_FREE_WR : ST_RESP;
			ST_FREE_WR:  state_nxt = ST_RESP;
			ST_RESP:     if (out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_PREP:     cmd.prep = 1'b1;
			ST_WALK_RD:  cmd.walk_rd = sts.walk_more;
			ST_WALK_CHK: begin
				cmd.walk_take = sts.hit;
				cmd.walk_step = !sts.hit;
			end
			ST_BUMP:     cmd.bump = 1'b1;
			ST_FREE_CHK: cmd.free_chk = 1'b1;
			ST_FREE_WR:  cmd.free_wr = 1'b1;
			ST_RESP:     cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// File: hdl/first_fit_heap_allocator.sv
// First-fit heap allocator with bump frontier, top level.
// Free checks the pointer and, unless it is stray, writes its header back as free;
// allocate reads and checks the headers below the frontier in turn (one header store
// read and one check per header), then takes the first hit or bumps the frontier.
// One item is in work at a time; the next item is taken while a result waits in
// the output register, and a result still waiting holds the next one.
// Reset (arst_n, async, low) clears base, size, frontier and control; header store
// contents are undefined until written and need no clearing pass.
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // [31:0] request_size, [63:32] block_pointer
	input  logic                 s_tuser,   // [0] opcode (0 allocate, 1 free)
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [31:0] payload_address
	output logic                 m_tuser,   // [0] out_of_memory
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index, // 0 heap_base, 1 heap_size
	input  logic [31:0]          cfg_data
);

	cmd_t    cmd;
	status_t sts;

	// Config is to be written only while idle; the block itself does not enforce this, so it is always taken.
	assign cfg_ready = 1'b1;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffha_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_opcode        (s_tuser),
		.in_request_size  (s_tdata[31:0]),
		.in_block_pointer (s_tdata[63:32]),
		.payload_address  (m_tdata),
		.out_of_memory    (m_tuser)
	);

	// One item in flight: no transfer taken right after another.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous item still in work");

	// A failed allocate always reports a null address.
	a_oom_null: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("out of memory with nonzero address");

	// At most one header store write source per cycle.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.walk_take, cmd.bump, cmd.free_wr}))
		else $error("conflicting header store writes");

	// Result register only loaded when the output slot is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && m_tvalid) |-> m_tready)
		else $error("pending result overwritten");

endmodule

// File: tb/heap_result_checker.sv
// Result checker for the first-fit heap allocator: watches request, result and
// register channels, predicts every result and compares it field by field.
// Depends on ffha_pkg.
module heap_result_checker
	import ffha_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [63:0]          s_tdata,   // [31:0] request_size, [63:32] block_pointer
	input  logic                 s_tuser,   // [0] opcode
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [31:0]          m_tdata,   // [31:0] payload_address
	input  logic                 m_tuser,   // [0] out_of_memory
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   outstanding,
	output int                   compared,
	output int                   oom_total,
	output int                   reuse_total
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] addr;
		logic        oom;
	} heap_result_t;

	heap_result_t       expected_results[$];
	logic [31:0]        base_q;
	logic [HSIZE_W-1:0] size_q;
	logic [FRONT_W-1:0] front_q;
	hdr_t               headers[HEAP_GRANULES];
	int                 mismatches;
	int                 n_compared;
	int                 n_oom;
	int                 n_reuse;

	function automatic logic [32:0] window_lo();
		return ({1'b0, base_q} + 33'd7) & ~33'd7;
	endfunction

	// Bytes usable from the aligned start; the end is capped at 2^32.
	function automatic logic [32:0] window_room();
		logic [33:0] hi;
		logic [33:0] lo;
		lo = {1'b0, window_lo()};
		hi = {2'b00, base_q} + {18'd0, size_q};
		if (hi > 34'h1_0000_0000)
			hi = 34'h1_0000_0000;
		return (hi > lo) ? 33'(hi - lo) : 33'd0;
	endfunction

	function automatic heap_result_t place_alloc(input logic [31:0] req);
		logic [32:0] bytes;
		logic [29:0] gran;
		logic [31:0] p;
		logic [31:0] need;
		logic [32:0] addr;
		bytes = ({1'b0, req} + 33'd7) & ~33'd7;
		if (bytes == 33'd0)
			bytes = 33'd8;
		gran = bytes[32:3];
		// first fit over existing blocks
		p = 32'd0;
		while (p < front_q) begin
			if (headers[p[GRAN_W-1:0]].free && headers[p[GRAN_W-1:0]].size >= gran) begin
				headers[p[GRAN_W-1:0]].free = 1'b0;
				n_reuse++;
				addr = window_lo() + {p[29:0], 3'b000} + 33'd8;
				return '{addr: addr[31:0], oom: 1'b0};
			end
			p = p + 32'd1 + headers[p[GRAN_W-1:0]].size;
		end
		// bump the frontier
		need = front_q + 32'd1 + gran;
		if (need > HEAP_GRANULES || {need, 3'b000} > {2'b00, window_room()}) begin
			n_oom++;
			return '{addr: 32'd0, oom: 1'b1};
		end
		addr = window_lo() + {front_q, 3'b000} + 33'd8;
		headers[front_q[GRAN_W-1:0]] = '{free: 1'b0, size: gran[SIZE_W-1:0]};
		front_q = need[FRONT_W-1:0];
		return '{addr: addr[31:0], oom: 1'b0};
	endfunction

	// Stray pointers (below the first payload, misaligned, past the frontier) do nothing.
	function automatic void release_block(input logic [31:0] ptr);
		logic [33:0] lo;
		logic [33:0] d;
		if (ptr == 32'd0)
			return;
		lo = {1'b0, window_lo()} + 34'd8;
		if ({2'b00, ptr} < lo)
			return;
		d = {2'b00, ptr} - lo;
		if (d[2:0] != 3'd0)
			return;
		if (d[33:3] < front_q)
			headers[d[GRAN_W+2:3]].free = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		heap_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			base_q     = '0;
			size_q     = '0;
			front_q    = '0;
			mismatches = 0;
			n_compared = 0;
			n_oom      = 0;
			n_reuse    = 0;
		end else begin
			// result side first: it can never belong to a request taken at this edge
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, payload_address %h out_of_memory %b",
						$time, m_tdata, m_tuser);
				end else begin
					want = expected_results.pop_front();
					n_compared++;
					if (m_tdata !== want.addr) begin
						mismatches++;
						$display("%0t: payload_address expected %h got %h",
							$time, want.addr, m_tdata);
					end
					if (m_tuser !== want.oom) begin
						mismatches++;
						$display("%0t: out_of_memory expected %b got %b",
							$time, want.oom, m_tuser);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_HEAP_BASE: begin
					base_q  = cfg_data;
					front_q = '0;
				end
				REG_HEAP_SIZE: begin
					size_q  = cfg_data[HSIZE_W-1:0];
					front_q = '0;
				end
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_ALLOC) begin
					expected_results.push_back(place_alloc(s_tdata[31:0]));
				end else begin
					release_block(s_tdata[63:32]);
					expected_results.push_back('{addr: 32'd0, oom: 1'b0});
				end
			end
		end
		errors      <= mismatches;
		outstanding <= expected_results.size();
		compared    <= n_compared;
		oom_total   <= n_oom;
		reuse_total <= n_reuse;
	end

endmodule

// File: tb/first_fit_heap_allocator_test.sv
// Testbench top for the first-fit heap allocator: reset, request and register
// stimulus, result back-pressure and the verdict.
// Depends on ffha_pkg, first_fit_heap_allocator and heap_result_checker.
module first_fit_heap_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	// Random settings keep the block count per setting at or below this, so it also
	// bounds the number of headers that a walk reads.
	localparam int MAX_HEADERS  = 128;
	localparam int LONG_HOLD    = 200;
	localparam int DRAIN_CYCLES = 4 + 2 * MAX_HEADERS;
	// Slowest legal run: every item walks the most headers, plus both sides' longest
	// waits, plus the one long result hold-off; then four times that.
	localparam int CYCLE_LIMIT  = 4 * ((RANDOM_ITEMS + 200) * (2 * MAX_HEADERS + 20) + LONG_HOLD);

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [63:0]          s_tdata;   // [31:0] request_size, [63:32] block_pointer
	logic                 s_tuser;   // [0] opcode
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;   // [31:0] payload_address
	logic                 m_tuser;   // [0] out_of_memory
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	int errors;
	int outstanding;
	int compared;
	int oom_total;
	int reuse_total;

	int                 cycles      = 0;
	int                 sent_count  = 0;
	int                 phase_count = 0;
	bit                 held_off    = 1'b0;
	logic [31:0]        cur_base;
	logic [HSIZE_W-1:0] cur_size;
	logic [31:0]        live_blocks[$];   // addresses handed out in this setting
	logic [31:0]        freed_blocks[$];  // addresses already given back once

	first_fit_heap_allocator DUT (.*);

	heap_result_checker results_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a hang or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Allocated addresses feed the free traffic of the random part.
	always @(posedge clk)
		if (m_tvalid && m_tready && m_tdata != 32'd0)
			live_blocks.push_back(m_tdata);

	// Every fourth stretch of 64 requests runs with no idle cycles on either side.
	function automatic bit no_idle();
		return (sent_count / 64) % 4 == 3;
	endfunction

	// Result side: after each transfer hold tready low for a random gap; once, after
	// a few hundred requests, hold it low long enough for the block to back up.
	initial begin : result_sink
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (!held_off && sent_count >= 300) begin
					held_off = 1'b1;
					hold     = LONG_HOLD;
				end else begin
					hold = no_idle() ? 0 : $urandom_range(0, 5);
				end
			end
		end
	end

	// One request transfer, preceded by a random idle gap. tvalid stays high into
	// the next request when that one has no gap.
	task automatic push_request(input logic op, input logic [31:0] req, input logic [31:0] ptr);
		int gap;
		gap = no_idle() ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {ptr, req};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// The unused field carries random bits; the block must ignore them.
	task automatic request_alloc(input logic [31:0] req);
		push_request(OP_ALLOC, req, $urandom);
	endtask

	task automatic request_free(input logic [31:0] ptr);
		push_request(OP_FREE, $urandom, ptr);
	endtask

	// Stop offering and wait until every owed result has been taken. Each request
	// yields a result, so the block is idle once none is owed.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// New heap window; either write sends the frontier back to the window start.
	task automatic set_heap(input logic [31:0] base, input logic [HSIZE_W-1:0] size);
		settle();
		write_reg(REG_HEAP_BASE, base);
		write_reg(REG_HEAP_SIZE, {16'd0, size});
		cur_base = base;
		cur_size = size;
		live_blocks.delete();
		freed_blocks.delete();
		phase_count++;
	endtask

	initial begin : stimulus
		int          n;
		int          k;
		int          random_sent;
		int unsigned min_req;
		int unsigned top_req;
		logic [31:0] ptr;
		logic [31:0] req;
		logic [32:0] win_lo;
		random_sent = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_ALLOC;
		cfg_valid = 1'b0;
		cfg_index = REG_HEAP_BASE;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed part ----
		// Reset leaves a zero-length window: nothing fits.
		request_alloc(32'd0);

		// Unaligned base 0x1003: window starts at 0x1008, 251 bytes (31 granules).
		// Payload of the block with header granule p sits at 0x1010 + 8p.
		set_heap(32'h0000_1003, 16'd256);
		request_alloc(32'd0);            // zero rounds to 8, header 0
		request_alloc(32'd1);            // header 2
		request_alloc(32'd17);           // 24 bytes, header 4, frontier 8
		request_free(32'd0);             // null free
		request_free(32'h0000_1010);
		request_free(32'h0000_1010);     // double free, block stays free
		request_alloc(32'd8);            // first fit takes header 0 again
		request_free(32'h0000_1021);     // misaligned
		request_free(32'h0000_1008);     // below the first payload
		request_free(32'h0000_1050);     // header at the frontier
		request_free(32'h0000_1038);     // inside a payload: the walk never sees it
		request_free(32'hFFFF_FFFF);
		request_alloc(32'hFFFF_FFFF);    // rounding must not wrap to zero
		request_alloc(32'hFFFF_FFF9);
		request_free(32'h0000_1030);     // 3-granule block freed
		request_alloc(32'd32);           // too big for it, bumps instead
		request_alloc(32'd16);           // fits the 3-granule block
		request_alloc(32'd136);          // fills the window to the last granule
		request_alloc(32'd0);            // full

		// Aligned start lands on 2^32: window too small.
		set_heap(32'hFFFF_FFFF, 16'd32768);
		request_alloc(32'd0);

		// Window end capped at 2^32; the block below ends exactly there.
		set_heap(32'hFFFF_F001, 16'd32768);
		request_alloc(32'd4080);
		request_alloc(32'd0);
		request_free(32'hFFFF_F010);
		request_alloc(32'd0);

		// Full-size window: one block reaches both the window and header store bounds.
		set_heap(32'h0000_0000, 16'd32768);
		request_alloc(32'd32760);
		request_alloc(32'd0);

		// Aligned start equals the end.
		set_heap(32'h0000_0005, 16'd3);
		request_alloc(32'd0);

		// ---- random part: settings of many shapes, mostly alloc/free of live blocks ----
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
			0: set_heap($urandom, 16'd32768);
			1: set_heap(32'hFFFF_FFFF - $urandom_range(0, 4000),
				HSIZE_W'($urandom_range(0, 2048)));
			2: set_heap($urandom, HSIZE_W'($urandom_range(0, 64)));
			3: set_heap(32'd0, HSIZE_W'($urandom_range(0, 32768)));
			default: set_heap($urandom, HSIZE_W'($urandom_range(64, 2048)));
			endcase
			win_lo = ({1'b0, cur_base} + 33'd7) & ~33'd7;
			// large windows get a floor on request size to bound the header count
			min_req = (cur_size > 2048) ? cur_size / 128 : 0;
			top_req = min_req + cur_size / 4 + 8;
			n = $urandom_range(40, 120);
			for (int i = 0; i < n && random_sent < RANDOM_ITEMS; i++) begin
				k = $urandom_range(0, 99);
				if (k >= 55 && k < 85 && live_blocks.size() > 0) begin
					k = $urandom_range(0, live_blocks.size() - 1);
					ptr = live_blocks[k];
					live_blocks.delete(k);
					freed_blocks.push_back(ptr);
					request_free(ptr);
				end else if (k >= 85 && k < 90 && freed_blocks.size() > 0) begin
					request_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
				end else if (k >= 90) begin
					// stray pointers
					case ($urandom_range(0, 3))
					0: ptr = 32'd0;
					1: ptr = $urandom;
					2: ptr = win_lo[31:0] + 32'd8 + 8 * $urandom_range(0, 300)
						+ $urandom_range(0, 7);
					default: ptr = win_lo[31:0] + $urandom_range(0, 7);
					endcase
					request_free(ptr);
				end else begin
					case ($urandom_range(0, 9))
					0: req = $urandom;
					1: req = min_req;
					2: req = 8 * $urandom_range(min_req / 8 + 1, top_req / 8 + 1);
					default: req = $urandom_range(min_req, top_req);
					endcase
					request_alloc(req);
				end
				random_sent++;
			end
		end

		// Drain, then give any late or extra result time to show up.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests over %0d heap settings, %0d results compared",
			sent_count, phase_count, compared);
		$display("%0d allocations reused a freed block, %0d found no room",
			reuse_total, oom_total);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
